// ===== hw/rtl/multiply_accumulate_long_unit_macros.svh =====
// Assertion macros for the multiply accumulate long unit.
// The macros expect signals named clock and reset in the calling module.
// Without the NO_ASSERTIONS define the macros expand to concurrent assertions.
`ifndef MULTIPLY_ACCUMULATE_LONG_UNIT_MACROS_SVH
`define MULTIPLY_ACCUMULATE_LONG_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define MAL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define MAL_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);
`else
`define MAL_ASSERT(label, prop, msg)
`define MAL_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== hw/rtl/mal_pkg.sv =====
// Shared types and constants for the multiply accumulate long unit.
// No dependencies; used by multiply_accumulate_long_unit.
package mal_pkg;

   localparam int WORD_W      = 32;
   localparam int DWORD_W     = 2 * WORD_W;
   localparam int MODE_W      = 4;
   localparam int REQ_FIELD_W = MODE_W + 4 * WORD_W;
   localparam int REQ_TDATA_W = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W = 2 * WORD_W + 3;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int SIGN_POS    = WORD_W - 1;

   // Mode field, bit 3 down to bit 0.
   typedef struct packed {
      logic is_long;
      logic is_signed;
      logic do_acc;
      logic set_flags;
   } mode_type;

endpackage

// ===== hw/rtl/multiply_accumulate_long_unit.sv =====
// Multiply accumulate long unit: MUL/MLA and UMULL/UMLAL/SMULL/SMLAL datapath.
// Depends on mal_pkg and multiply_accumulate_long_unit_macros.svh.
//
// Usage:
//   The req channel carries one multiply instruction per transfer: mode,
//   multiplicand, multiplier and the low and high accumulator words. The rsp
//   channel returns one result per instruction, in order: low and high result
//   words, the flags-written bit and the N and Z flags.
//   Throughput is one instruction per cycle while rsp is not stalled; the
//   four stages are operand decode with the signed correction, the 32x32
//   multiplier, the 64-bit accumulate adder and the flag logic with the
//   output register, and an instruction passes through them in that order
//   before its result shows on rsp.
//   A stalled rsp holds its result; each stage with a bubble still fills, so
//   req_tready stays high until every stage holds an item.
//   Synchronous reset empties all stages; no item survives it.
`include "multiply_accumulate_long_unit_macros.svh"

module multiply_accumulate_long_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // mode[3:0], multiplicand[35:4], multiplier[67:36], acc_low[99:68],
   // acc_high[131:100], zero fill above
   input  logic [mal_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // result_low[31:0], result_high[63:32], flags_written[64],
   // negative_flag[65], zero_flag[66], zero fill above
   output logic [mal_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import mal_pkg::*;

   // request fields
   mode_type            req_mode;
   logic [WORD_W-1:0]   req_a;
   logic [WORD_W-1:0]   req_b;
   logic [WORD_W-1:0]   req_acc_low;
   logic [WORD_W-1:0]   req_acc_high;

   // stage advance
   logic adv1;
   logic adv2;
   logic adv3;
   logic adv4;

   // stage 1: decoded operands and combined addend
   logic                s1_valid_ff;
   mode_type            s1_mode_ff;
   logic [WORD_W-1:0]   s1_a_ff;
   logic [WORD_W-1:0]   s1_b_ff;
   logic [DWORD_W-1:0]  s1_addend_ff;
   logic [DWORD_W-1:0]  s1_addend_in;
   logic [WORD_W-1:0]   acc_lo_sel;
   logic [WORD_W-1:0]   acc_hi_sel;
   logic [WORD_W-1:0]   corr_a;
   logic [WORD_W-1:0]   corr_b;

   // stage 2: product
   logic                s2_valid_ff;
   mode_type            s2_mode_ff;
   logic [DWORD_W-1:0]  s2_prod_ff;
   logic [DWORD_W-1:0]  s2_prod_in;
   logic [DWORD_W-1:0]  s2_addend_ff;

   // stage 3: sum
   logic                s3_valid_ff;
   mode_type            s3_mode_ff;
   logic [DWORD_W-1:0]  s3_sum_ff;
   logic [DWORD_W-1:0]  s3_sum_in;

   // stage 4: result register
   logic                rsp_valid_ff;
   logic [WORD_W-1:0]   rsp_low_ff;
   logic [WORD_W-1:0]   rsp_high_ff;
   logic                rsp_fw_ff;
   logic                rsp_neg_ff;
   logic                rsp_zero_ff;
   logic [WORD_W-1:0]   rsp_low_in;
   logic [WORD_W-1:0]   rsp_high_in;
   logic                rsp_neg_in;
   logic                rsp_zero_in;

   assign req_mode     = mode_type'(req_tdata[MODE_W-1:0]);
   assign req_a        = req_tdata[MODE_W +: WORD_W];
   assign req_b        = req_tdata[MODE_W + WORD_W +: WORD_W];
   assign req_acc_low  = req_tdata[MODE_W + 2*WORD_W +: WORD_W];
   assign req_acc_high = req_tdata[MODE_W + 3*WORD_W +: WORD_W];

   // a stage loads when it is empty or its content moves on
   assign adv4       = !rsp_valid_ff || rsp_tready;
   assign adv3       = !s3_valid_ff || adv4;
   assign adv2       = !s2_valid_ff || adv3;
   assign adv1       = !s1_valid_ff || adv2;
   assign req_tready = adv1;

   // Fold accumulator and signed high-word correction into one addend.
   always_comb begin
      acc_lo_sel = req_mode.do_acc ? req_acc_low : '0;
      acc_hi_sel = (req_mode.do_acc && req_mode.is_long) ? req_acc_high : '0;
      corr_a = (req_mode.is_long && req_mode.is_signed && req_a[SIGN_POS]) ? req_b : '0;
      corr_b = (req_mode.is_long && req_mode.is_signed && req_b[SIGN_POS]) ? req_a : '0;
      s1_addend_in = {acc_hi_sel - corr_a - corr_b, acc_lo_sel};
   end

   assign s2_prod_in = DWORD_W'(s1_a_ff) * DWORD_W'(s1_b_ff);
   assign s3_sum_in  = s2_prod_ff + s2_addend_ff;

   always_comb begin
      rsp_low_in  = s3_sum_ff[WORD_W-1:0];
      rsp_high_in = s3_mode_ff.is_long ? s3_sum_ff[DWORD_W-1:WORD_W] : '0;
      rsp_neg_in  = s3_mode_ff.set_flags &&
                    (s3_mode_ff.is_long ? rsp_high_in[SIGN_POS] : rsp_low_in[SIGN_POS]);
      rsp_zero_in = s3_mode_ff.set_flags && (rsp_low_in == '0) && (rsp_high_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv1) begin
            s1_valid_ff <= req_tvalid;
         end
         if (adv2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (adv3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (adv4) begin
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_mode_ff   <= req_mode;
         s1_a_ff      <= req_a;
         s1_b_ff      <= req_b;
         s1_addend_ff <= s1_addend_in;
      end
      if (adv2) begin
         s2_mode_ff   <= s1_mode_ff;
         s2_prod_ff   <= s2_prod_in;
         s2_addend_ff <= s1_addend_ff;
      end
      if (adv3) begin
         s3_mode_ff <= s2_mode_ff;
         s3_sum_ff  <= s3_sum_in;
      end
      if (adv4) begin
         rsp_low_ff  <= rsp_low_in;
         rsp_high_ff <= rsp_high_in;
         rsp_fw_ff   <= s3_mode_ff.set_flags;
         rsp_neg_ff  <= rsp_neg_in;
         rsp_zero_ff <= rsp_zero_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - RSP_FIELD_W)'(0), rsp_zero_ff, rsp_neg_ff, rsp_fw_ff,
                        rsp_high_ff, rsp_low_ff};

   `MAL_ASSERT(a_flags_clear, (rsp_valid_ff && !rsp_fw_ff) |-> (!rsp_neg_ff && !rsp_zero_ff), "flags set without set-flags bit")
   `MAL_ASSERT(a_zero_match, (rsp_valid_ff && rsp_zero_ff) |-> (rsp_low_ff == '0 && rsp_high_ff == '0), "zero flag with nonzero result")
   `MAL_ASSERT(a_bubble_fill, (s1_valid_ff && !s2_valid_ff) |=> s2_valid_ff, "stage 1 item did not move into empty stage 2")
   `MAL_ASSERT_ALWAYS(a_ready_bubble, !s1_valid_ff |-> req_tready, "ready low with empty first stage")

endmodule
